// ===== hw/rtl/cbor_item_tokenizer_defines.svh =====
// assertion helpers used by cbor_item_tokenizer.sv
`ifndef CBOR_ITEM_TOKENIZER_DEFINES_SVH
`define CBOR_ITEM_TOKENIZER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CBORTOK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CBORTOK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cbortok_pkg.sv =====
package cbortok_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_ARG     = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DISCARD = 2'd3
    } phase_t;

    localparam logic [1:0] WHAT_TOKEN   = 2'd0;
    localparam logic [1:0] WHAT_PAYLOAD = 2'd1;
    localparam logic [1:0] WHAT_ERROR   = 2'd2;

    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_OVERRUN     = 2'd1;
    localparam logic [1:0] ERR_UNSUPPORTED = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW    = 2'd3;

    localparam logic [2:0] TYPE_UINT  = 3'd0;
    localparam logic [2:0] TYPE_BYTES = 3'd1;
    localparam logic [2:0] TYPE_TEXT  = 3'd2;
    localparam logic [2:0] TYPE_ARRAY = 3'd3;
    localparam logic [2:0] TYPE_MAP   = 3'd4;
    localparam logic [2:0] TYPE_BOOL  = 3'd5;
    localparam logic [2:0] TYPE_NULL  = 3'd6;

    localparam logic [2:0] MT_UINT   = 3'd0;
    localparam logic [2:0] MT_NEGINT = 3'd1;
    localparam logic [2:0] MT_BYTES  = 3'd2;
    localparam logic [2:0] MT_TEXT   = 3'd3;
    localparam logic [2:0] MT_ARRAY  = 3'd4;
    localparam logic [2:0] MT_MAP    = 3'd5;
    localparam logic [2:0] MT_TAG    = 3'd6;
    localparam logic [2:0] MT_SIMPLE = 3'd7;

    localparam logic [4:0] AI_FALSE    = 5'd20;
    localparam logic [4:0] AI_TRUE     = 5'd21;
    localparam logic [4:0] AI_NULL     = 5'd22;
    localparam logic [4:0] AI_MAX_IMM  = 5'd23;
    localparam logic [4:0] AI_MAX_ARGS = 5'd27;

    localparam logic [23:0] LEN_LIMIT_RESET = 24'hffffff;

    typedef struct packed {
        phase_t        phase;
        logic [2:0]    major_type;
        logic [3:0]    arg_left;
        logic [63:0]   arg_accum;
        logic [3:0]    hdr_seen;
        logic [23:0]   payload_left;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:        PH_HEADER,
        major_type:   3'd0,
        arg_left:     4'd0,
        arg_accum:    64'd0,
        hdr_seen:     4'd0,
        payload_left: 24'd0
    };

    typedef struct packed {
        logic [1:0]  what;
        logic [2:0]  item_type;
        logic [63:0] value;
        logic [3:0]  header_size;
        logic [7:0]  payload_byte;
        logic        item_done;
        logic        top_done;
        logic [1:0]  error_code;
    } result_t;

    function automatic logic [2:0] type_code(input logic [2:0] mt);
        logic [2:0] t;
        unique case (mt)
            MT_BYTES: t = TYPE_BYTES;
            MT_TEXT:  t = TYPE_TEXT;
            MT_ARRAY: t = TYPE_ARRAY;
            MT_MAP:   t = TYPE_MAP;
            default:  t = TYPE_UINT;
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/cbortok_step.sv =====
module cbortok_step #(
    parameter int OWED_WIDTH = 32
) (
    input  cbortok_pkg::state_t    st,
    input  logic [OWED_WIDTH-1:0]  owed,
    input  logic [7:0]             in_byte,
    input  logic                   eob,
    input  logic [23:0]            len_limit,
    output cbortok_pkg::state_t    st_next,
    output logic [OWED_WIDTH-1:0]  owed_next,
    output logic                   res_vld,
    output cbortok_pkg::result_t   res
);

    logic [2:0]            hdr_mt;
    logic [4:0]            hdr_low;
    logic [3:0]            arg_left_dec;
    logic [23:0]           pl_dec;
    logic                  fin_req;
    logic [63:0]           fin_value;
    logic [3:0]            fin_hs;
    logic [2:0]            fin_mt;
    logic                  cmp_req;
    logic [24:0]           cmp_add;
    logic                  fail_req;
    logic [1:0]            fail_code;
    logic                  restart;
    logic [OWED_WIDTH-1:0] owed_cur;
    logic [OWED_WIDTH:0]   owed_sum;
    logic                  top;

    assign hdr_mt       = in_byte[7:5];
    assign hdr_low      = in_byte[4:0];
    assign arg_left_dec = (st.arg_left != 4'd0) ? st.arg_left - 4'd1 : 4'd0;
    assign pl_dec       = (st.payload_left != 24'd0) ? st.payload_left - 24'd1 : 24'd0;
    assign owed_cur     = (owed == '0) ? {{(OWED_WIDTH-1){1'b0}}, 1'b1} : owed;

    always_comb
    begin
        st_next   = st;
        owed_next = owed;
        res_vld   = 1'b0;
        res       = '0;
        fin_req   = 1'b0;
        fin_value = 64'd0;
        fin_hs    = st.hdr_seen;
        cmp_req   = 1'b0;
        cmp_add   = 25'd0;
        fail_req  = 1'b0;
        fail_code = cbortok_pkg::ERR_NONE;
        restart   = 1'b0;
        owed_sum  = '0;
        top       = 1'b0;

        unique case (st.phase)
            cbortok_pkg::PH_DISCARD:
            begin
                restart = eob;
            end
            cbortok_pkg::PH_ARG:
            begin
                st_next.arg_accum = {st.arg_accum[55:0], in_byte};
                st_next.hdr_seen  = st.hdr_seen + 4'd1;
                st_next.arg_left  = arg_left_dec;
                if (arg_left_dec == 4'd0)
                begin
                    fin_req   = 1'b1;
                    fin_value = {st.arg_accum[55:0], in_byte};
                    fin_hs    = st.hdr_seen + 4'd1;
                end
                else if (eob)
                begin
                    fail_req  = 1'b1;
                    fail_code = cbortok_pkg::ERR_OVERRUN;
                end
            end
            cbortok_pkg::PH_PAYLOAD:
            begin
                st_next.payload_left = pl_dec;
                res.what         = cbortok_pkg::WHAT_PAYLOAD;
                res.item_type    = cbortok_pkg::type_code(st.major_type);
                res.payload_byte = in_byte;
                if (pl_dec != 24'd0)
                begin
                    if (eob)
                    begin
                        fail_req  = 1'b1;
                        fail_code = cbortok_pkg::ERR_OVERRUN;
                    end
                    else
                    begin
                        res_vld = 1'b1;
                    end
                end
                else
                begin
                    cmp_req = 1'b1;
                end
            end
            cbortok_pkg::PH_HEADER:
            begin
                st_next.hdr_seen = 4'd1;
                if (hdr_mt == cbortok_pkg::MT_SIMPLE)
                begin
                    if (hdr_low == cbortok_pkg::AI_FALSE || hdr_low == cbortok_pkg::AI_TRUE)
                    begin
                        res.what        = cbortok_pkg::WHAT_TOKEN;
                        res.item_type   = cbortok_pkg::TYPE_BOOL;
                        res.value       = {63'd0, hdr_low == cbortok_pkg::AI_TRUE};
                        res.header_size = 4'd1;
                        cmp_req         = 1'b1;
                    end
                    else if (hdr_low == cbortok_pkg::AI_NULL)
                    begin
                        res.what        = cbortok_pkg::WHAT_TOKEN;
                        res.item_type   = cbortok_pkg::TYPE_NULL;
                        res.header_size = 4'd1;
                        cmp_req         = 1'b1;
                    end
                    else
                    begin
                        fail_req  = 1'b1;
                        fail_code = cbortok_pkg::ERR_UNSUPPORTED;
                    end
                end
                else if (hdr_mt == cbortok_pkg::MT_NEGINT || hdr_mt == cbortok_pkg::MT_TAG)
                begin
                    fail_req  = 1'b1;
                    fail_code = cbortok_pkg::ERR_UNSUPPORTED;
                end
                else
                begin
                    st_next.major_type = hdr_mt;
                    if (hdr_low <= cbortok_pkg::AI_MAX_IMM)
                    begin
                        fin_req   = 1'b1;
                        fin_value = {59'd0, hdr_low};
                        fin_hs    = 4'd1;
                    end
                    else if (hdr_low > cbortok_pkg::AI_MAX_ARGS)
                    begin
                        fail_req  = 1'b1;
                        fail_code = cbortok_pkg::ERR_UNSUPPORTED;
                    end
                    else if (eob)
                    begin
                        fail_req  = 1'b1;
                        fail_code = cbortok_pkg::ERR_OVERRUN;
                    end
                    else
                    begin
                        st_next.arg_left  = 4'd1 << hdr_low[1:0];
                        st_next.arg_accum = 64'd0;
                        st_next.phase     = cbortok_pkg::PH_ARG;
                    end
                end
            end
            default:
            begin
                restart = eob;
            end
        endcase

        // header complete
        fin_mt = st_next.major_type;
        if (fin_req)
        begin
            st_next.phase   = cbortok_pkg::PH_HEADER;
            res.what        = cbortok_pkg::WHAT_TOKEN;
            res.item_type   = cbortok_pkg::type_code(fin_mt);
            res.value       = fin_value;
            res.header_size = fin_hs;
            if (fin_mt >= cbortok_pkg::MT_BYTES && fin_mt <= cbortok_pkg::MT_MAP
                && fin_value > {40'd0, len_limit})
            begin
                fail_req  = 1'b1;
                fail_code = cbortok_pkg::ERR_OVERFLOW;
            end
            else if (fin_mt == cbortok_pkg::MT_ARRAY)
            begin
                cmp_req = 1'b1;
                cmp_add = {1'b0, fin_value[23:0]};
            end
            else if (fin_mt == cbortok_pkg::MT_MAP)
            begin
                cmp_req = 1'b1;
                cmp_add = {fin_value[23:0], 1'b0};
            end
            else if ((fin_mt == cbortok_pkg::MT_BYTES || fin_mt == cbortok_pkg::MT_TEXT)
                     && fin_value != 64'd0)
            begin
                if (eob)
                begin
                    fail_req  = 1'b1;
                    fail_code = cbortok_pkg::ERR_OVERRUN;
                end
                else
                begin
                    st_next.phase        = cbortok_pkg::PH_PAYLOAD;
                    st_next.payload_left = fin_value[23:0];
                    st_next.hdr_seen     = 4'd0;
                    res_vld              = 1'b1;
                end
            end
            else
            begin
                cmp_req = 1'b1;
            end
        end

        // item complete: settle the owed count
        if (cmp_req && !fail_req)
        begin
            owed_sum = {1'b0, owed_cur} - {{OWED_WIDTH{1'b0}}, 1'b1}
                       + {{(OWED_WIDTH-24){1'b0}}, cmp_add};
            top = (owed_sum == '0);
            if (owed_sum[OWED_WIDTH])
            begin
                fail_req  = 1'b1;
                fail_code = cbortok_pkg::ERR_OVERFLOW;
            end
            else if (eob && !top)
            begin
                fail_req  = 1'b1;
                fail_code = cbortok_pkg::ERR_OVERRUN;
            end
            else
            begin
                st_next.phase    = cbortok_pkg::PH_HEADER;
                st_next.hdr_seen = 4'd0;
                owed_next        = top ? {{(OWED_WIDTH-1){1'b0}}, 1'b1}
                                       : owed_sum[OWED_WIDTH-1:0];
                res.item_done    = 1'b1;
                res.top_done     = top;
                res_vld          = 1'b1;
                restart          = eob;
            end
        end

        if (fail_req)
        begin
            res            = '0;
            res.what       = cbortok_pkg::WHAT_ERROR;
            res.error_code = fail_code;
            res_vld        = 1'b1;
            if (eob)
            begin
                restart = 1'b1;
            end
            else
            begin
                st_next.phase = cbortok_pkg::PH_DISCARD;
            end
        end

        if (restart)
        begin
            st_next   = cbortok_pkg::STATE_RESET;
            owed_next = {{(OWED_WIDTH-1){1'b0}}, 1'b1};
        end
    end

endmodule

// ===== hw/rtl/cbor_item_tokenizer.sv =====
// cbor_item_tokenizer: streaming tokenizer for a subset of cbor
// input channel: one buffer byte per transaction (in_byte, end_of_buffer),
//   taken on a clock edge with in_valid high and in_stall low
// output channel: zero or one result transaction per input byte (what,
//   item_type, value, header_size, payload_byte, item_done, top_done,
//   error_code), taken with out_valid high and out_stall low
// a taken byte is decoded from the input register into the result register,
//   which drives out_valid; one byte per cycle is sustained while out_stall is
//   low, set by the single decode and owed-count update between these registers
// write the length limit (apb byte address 0) only while idle; not enforced
// reset: decoder returns to expecting a header with one item owed, both
//   channel registers empty, length limit back to 0xffffff
// when the receiver stalls, the held result stays on the port and one more
//   byte is taken into the input register; then in_stall rises until the
//   result is taken
// after an error no result is produced until the byte with end_of_buffer
module cbor_item_tokenizer #(
    parameter int OWED_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        end_of_buffer,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  what,
    output logic [2:0]  item_type,
    output logic [63:0] value,
    output logic [3:0]  header_size,
    output logic [7:0]  payload_byte,
    output logic        item_done,
    output logic        top_done,
    output logic [1:0]  error_code,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    `include "cbor_item_tokenizer_defines.svh"

    localparam logic REG_LEN_LIMIT = 1'b0;

    logic                  in_vld_reg;
    logic                  in_vld_next;
    logic [7:0]            in_byte_reg;
    logic                  in_eob_reg;
    logic                  out_vld_reg;
    logic                  out_vld_next;
    cbortok_pkg::result_t  res_reg;
    cbortok_pkg::state_t   state_reg;
    cbortok_pkg::state_t   state_next;
    logic [OWED_WIDTH-1:0] owed_reg;
    logic [OWED_WIDTH-1:0] owed_next;
    logic [23:0]           len_limit_reg;
    logic                  advance;
    logic                  in_take;
    logic                  res_vld;
    cbortok_pkg::result_t  res;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_LEN_LIMIT) ? {8'd0, len_limit_reg} : 32'd0;

    cbortok_step #(
        .OWED_WIDTH(OWED_WIDTH)
    ) u_step (
        .st        (state_reg),
        .owed      (owed_reg),
        .in_byte   (in_byte_reg),
        .eob       (in_eob_reg),
        .len_limit (len_limit_reg),
        .st_next   (state_next),
        .owed_next (owed_next),
        .res_vld   (res_vld),
        .res       (res)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = res_vld;
        end
        else if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            state_reg     <= cbortok_pkg::STATE_RESET;
            owed_reg      <= {{(OWED_WIDTH-1){1'b0}}, 1'b1};
            len_limit_reg <= cbortok_pkg::LEN_LIMIT_RESET;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                state_reg <= state_next;
                owed_reg  <= owed_next;
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_LEN_LIMIT)
            begin
                len_limit_reg <= pwdata[23:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= in_byte;
            in_eob_reg  <= end_of_buffer;
        end
        if (advance && res_vld)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_vld_reg;
    assign what         = res_reg.what;
    assign item_type    = res_reg.item_type;
    assign value        = res_reg.value;
    assign header_size  = res_reg.header_size;
    assign payload_byte = res_reg.payload_byte;
    assign item_done    = res_reg.item_done;
    assign top_done     = res_reg.top_done;
    assign error_code   = res_reg.error_code;

    `CBORTOK_ASSERT_NOW(a_owed_nonzero, 1'b1, owed_reg != '0, "owed count reached zero")
    `CBORTOK_ASSERT_NOW(a_payload_left, state_reg.phase == cbortok_pkg::PH_PAYLOAD,
        state_reg.payload_left != 24'd0, "payload phase with nothing left")
    `CBORTOK_ASSERT_NOW(a_top_done_item, out_vld_reg && res_reg.top_done,
        res_reg.item_done, "top item done without item done")
    `CBORTOK_ASSERT_NEXT(a_error_discard,
        advance && res_vld && res.what == cbortok_pkg::WHAT_ERROR && !in_eob_reg,
        state_reg.phase == cbortok_pkg::PH_DISCARD, "error did not enter discard")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import cbortok_pkg::*;

    localparam int OWED_W = 32;
    localparam logic [63:0] OWED_LIMIT = (64'd1 << OWED_W) - 64'd1;
    localparam logic [2:0] REG_LEN_LIMIT = 3'd0;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES = 100;
    localparam int LONG_HOLD = 300;
    localparam int TIMEOUT_NS = 10_000_000;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SOME} idle_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'd0;
    logic        end_of_buffer = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  what;
    logic [2:0]  item_type;
    logic [63:0] value;
    logic [3:0]  header_size;
    logic [7:0]  payload_byte;
    logic        item_done;
    logic        top_done;
    logic [1:0]  error_code;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    idle_mode_t tx_mode = IDLE_NONE;
    idle_mode_t rx_mode = IDLE_NONE;
    int hold_cycles = 0;
    logic [7:0] cbor_bytes[$];

    // eob flag in bit 8
    logic [8:0] opening_bytes [23] = '{
        9'h100, 9'h1ff, 9'h1f5, 9'h1f6, 9'h042, 9'h061, 9'h162, 9'h0a1,
        9'h001, 9'h180, 9'h182, 9'h0c1, 9'h100, 9'h001, 9'h117, 9'h15c,
        9'h05a, 9'h0ff, 9'h0ff, 9'h0ff, 9'h1ff, 9'h019, 9'h101
    };

    cbor_item_tokenizer #(.OWED_WIDTH(OWED_W)) dut (.*);

    always #6 clk = ~clk;

    class token_scoreboard;
        result_t     expected_q[$];
        int unsigned mismatches;
        int unsigned live_bytes;
        logic [23:0] max_len;
        phase_t      ph;
        logic [2:0]  mtype;
        logic [3:0]  arg_left;
        logic [63:0] accum;
        logic [3:0]  hdr_cnt;
        logic [23:0] pay_left;
        logic [63:0] owed;

        function new();
            mismatches = 0;
            live_bytes = 0;
            max_len = LEN_LIMIT_RESET;
            restart();
        endfunction

        function void restart();
            ph = PH_HEADER;
            mtype = '0;
            arg_left = '0;
            accum = '0;
            hdr_cnt = '0;
            pay_left = '0;
            owed = 64'd1;
        endfunction

        task report(string msg);
            if (mismatches < 100)
                $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        function logic [2:0] token_type(logic [2:0] mt);
            case (mt)
                MT_BYTES: return TYPE_BYTES;
                MT_TEXT:  return TYPE_TEXT;
                MT_ARRAY: return TYPE_ARRAY;
                MT_MAP:   return TYPE_MAP;
                default:  return TYPE_UINT;
            endcase
        endfunction

        function void push_result(logic [1:0] kind, logic [2:0] t, logic [63:0] val,
                                  logic [3:0] hs, logic [7:0] pb, logic idone,
                                  logic tdone, logic [1:0] err);
            result_t r;
            r.what = kind;
            r.item_type = t;
            r.value = val;
            r.header_size = hs;
            r.payload_byte = pb;
            r.item_done = idone;
            r.top_done = tdone;
            r.error_code = err;
            expected_q.push_back(r);
        endfunction

        function void raise_error(logic [1:0] code, bit eob);
            if (eob)
                restart();
            else
                ph = PH_DISCARD;
            push_result(WHAT_ERROR, '0, '0, '0, '0, 1'b0, 1'b0, code);
        endfunction

        // item finished: settle the owed count
        function void close_item(logic [1:0] kind, logic [2:0] t, logic [63:0] val,
                                 logic [3:0] hs, logic [7:0] pb, logic [63:0] add,
                                 bit eob);
            logic [63:0] cur;
            logic [63:0] nxt;
            bit top;
            cur = (owed == 64'd0) ? 64'd1 : owed;
            nxt = cur - 64'd1 + add;
            if (nxt > OWED_LIMIT)
            begin
                raise_error(ERR_OVERFLOW, eob);
                return;
            end
            top = (nxt == 64'd0);
            if (eob && !top)
            begin
                raise_error(ERR_OVERRUN, eob);
                return;
            end
            ph = PH_HEADER;
            hdr_cnt = '0;
            owed = top ? 64'd1 : nxt;
            if (eob)
                restart();
            push_result(kind, t, val, hs, pb, 1'b1, top, ERR_NONE);
        endfunction

        function void end_header(logic [63:0] val, bit eob);
            logic [2:0] t;
            t = token_type(mtype);
            ph = PH_HEADER;
            if (mtype >= MT_BYTES && mtype <= MT_MAP && val > {40'd0, max_len})
                raise_error(ERR_OVERFLOW, eob);
            else if (mtype == MT_ARRAY)
                close_item(WHAT_TOKEN, t, val, hdr_cnt, '0, val, eob);
            else if (mtype == MT_MAP)
                close_item(WHAT_TOKEN, t, val, hdr_cnt, '0, val << 1, eob);
            else if ((mtype == MT_BYTES || mtype == MT_TEXT) && val != 64'd0)
            begin
                if (eob)
                    raise_error(ERR_OVERRUN, eob);
                else
                begin
                    ph = PH_PAYLOAD;
                    pay_left = val[23:0];
                    push_result(WHAT_TOKEN, t, val, hdr_cnt, '0, 1'b0, 1'b0, ERR_NONE);
                    hdr_cnt = '0;
                end
            end
            else
                close_item(WHAT_TOKEN, t, val, hdr_cnt, '0, '0, eob);
        endfunction

        function void note_input_byte(logic [7:0] b, bit eob);
            logic [2:0] mt;
            logic [4:0] low;
            if (ph != PH_DISCARD)
                live_bytes++;
            case (ph)
                PH_DISCARD:
                begin
                    if (eob)
                        restart();
                end
                PH_ARG:
                begin
                    accum = {accum[55:0], b};
                    hdr_cnt = hdr_cnt + 4'd1;
                    if (arg_left != 4'd0)
                        arg_left = arg_left - 4'd1;
                    if (arg_left == 4'd0)
                        end_header(accum, eob);
                    else if (eob)
                        raise_error(ERR_OVERRUN, eob);
                end
                PH_PAYLOAD:
                begin
                    if (pay_left != 24'd0)
                        pay_left = pay_left - 24'd1;
                    if (pay_left == 24'd0)
                        close_item(WHAT_PAYLOAD, token_type(mtype), '0, '0, b, '0, eob);
                    else if (eob)
                        raise_error(ERR_OVERRUN, eob);
                    else
                        push_result(WHAT_PAYLOAD, token_type(mtype), '0, '0, b,
                                    1'b0, 1'b0, ERR_NONE);
                end
                default:
                begin
                    mt = b[7:5];
                    low = b[4:0];
                    hdr_cnt = 4'd1;
                    if (mt == MT_SIMPLE)
                    begin
                        if (low == AI_FALSE || low == AI_TRUE)
                            close_item(WHAT_TOKEN, TYPE_BOOL, {63'd0, low == AI_TRUE}, 4'd1,
                                       '0, '0, eob);
                        else if (low == AI_NULL)
                            close_item(WHAT_TOKEN, TYPE_NULL, '0, 4'd1, '0, '0, eob);
                        else
                            raise_error(ERR_UNSUPPORTED, eob);
                    end
                    else if (mt == MT_NEGINT || mt == MT_TAG)
                        raise_error(ERR_UNSUPPORTED, eob);
                    else
                    begin
                        mtype = mt;
                        if (low <= AI_MAX_IMM)
                            end_header({59'd0, low}, eob);
                        else if (low > AI_MAX_ARGS)
                            raise_error(ERR_UNSUPPORTED, eob);
                        else if (eob)
                            raise_error(ERR_OVERRUN, eob);
                        else
                        begin
                            // 1, 2, 4 or 8 argument bytes
                            arg_left = 4'd1 << low[1:0];
                            accum = '0;
                            ph = PH_ARG;
                        end
                    end
                end
            endcase
        endfunction

        task field_check(string name, logic [63:0] got_v, logic [63:0] exp_v);
            if (got_v !== exp_v)
                report($sformatf("%s got 0x%0h expected 0x%0h", name, got_v, exp_v));
        endtask

        task check_result(result_t got);
            result_t exp_r;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result with nothing expected: what=%0d error_code=%0d",
                                 got.what, got.error_code));
                return;
            end
            exp_r = expected_q.pop_front();
            field_check("what", got.what, exp_r.what);
            field_check("item_type", got.item_type, exp_r.item_type);
            field_check("value", got.value, exp_r.value);
            field_check("header_size", got.header_size, exp_r.header_size);
            field_check("payload_byte", got.payload_byte, exp_r.payload_byte);
            field_check("item_done", got.item_done, exp_r.item_done);
            field_check("top_done", got.top_done, exp_r.top_done);
            field_check("error_code", got.error_code, exp_r.error_code);
        endtask
    endclass

    token_scoreboard sb;

    function automatic int draw_gap(idle_mode_t mode);
        if (mode == IDLE_NONE)
            return 0;
        if (mode == IDLE_SOME && $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    // header with immediate or 1/2/4/8-byte argument, not always minimal
    function automatic void put_head(logic [2:0] mt, logic [63:0] val);
        logic [7:0] hb;
        int pick;
        hb = {mt, 5'd0};
        if (val <= AI_MAX_IMM && $urandom_range(0, 3) != 0)
        begin
            hb[4:0] = val[4:0];
            cbor_bytes.push_back(hb);
            return;
        end
        pick = $urandom_range(0, 3);
        while (pick < 3 && (val >> (8 << pick)) != 64'd0)
            pick++;
        hb[4:0] = AI_MAX_IMM + 5'd1 + 5'(pick);
        cbor_bytes.push_back(hb);
        for (int i = (1 << pick) - 1; i >= 0; i--)
            cbor_bytes.push_back(val[8*i +: 8]);
    endfunction

    function automatic void put_item(int depth);
        logic [63:0] v;
        logic [7:0] hb;
        int n;
        case ($urandom_range(0, depth >= 3 ? 2 : 4))
            0:
            begin
                v = {$urandom, $urandom};
                v = v >> $urandom_range(0, 64);
                if ($urandom_range(0, 15) == 0)
                    v = '1;
                put_head(MT_UINT, v);
            end
            1:
            begin
                n = $urandom_range(0, 6);
                put_head($urandom_range(0, 1) ? MT_BYTES : MT_TEXT, 64'(n));
                repeat (n) cbor_bytes.push_back(8'($urandom_range(0, 255)));
            end
            2:
            begin
                hb = {MT_SIMPLE, AI_FALSE};
                hb[4:0] = hb[4:0] + 5'($urandom_range(0, 2));
                cbor_bytes.push_back(hb);
            end
            3:
            begin
                n = $urandom_range(0, 3);
                put_head(MT_ARRAY, 64'(n));
                repeat (n) put_item(depth + 1);
            end
            default:
            begin
                n = $urandom_range(0, 2);
                put_head(MT_MAP, 64'(n));
                repeat (2 * n) put_item(depth + 1);
            end
        endcase
    endfunction

    function automatic void put_bad();
        logic [7:0] hb;
        logic [2:0] mt;
        hb = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 4))
            0: hb[7:5] = MT_NEGINT;
            1: hb[7:5] = MT_TAG;
            2:
            begin
                hb[7:5] = MT_SIMPLE;
                while (hb[4:0] == AI_FALSE || hb[4:0] == AI_TRUE || hb[4:0] == AI_NULL)
                    hb[4:0] = 5'($urandom_range(0, 31));
            end
            3: hb[4:0] = AI_MAX_ARGS + 5'd1 + 5'($urandom_range(0, 3));
            default:
            begin
                mt = MT_BYTES + 3'($urandom_range(0, 3));
                put_head(mt, {40'd0, sb.max_len} + 64'd1 + 64'($urandom_range(0, 1000)));
                return;
            end
        endcase
        cbor_bytes.push_back(hb);
    endfunction

    task automatic send_byte(logic [7:0] b, logic eob);
        int gap;
        gap = draw_gap(tx_mode);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        end_of_buffer <= eob;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.note_input_byte(b, eob);
        @(negedge clk);
    endtask

    task automatic send_buffer();
        for (int i = 0; i < cbor_bytes.size(); i++)
            send_byte(cbor_bytes[i], i == cbor_bytes.size() - 1);
        cbor_bytes.delete();
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_len_limit(logic [23:0] len);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_LEN_LIMIT;
        pwdata <= {8'd0, len};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        sb.max_len = len;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_buffer();
        int sel;
        int cut;
        cbor_bytes.delete();
        sel = $urandom_range(0, 19);
        if (sel < 12)
            repeat ($urandom_range(1, 3)) put_item(0);
        else if (sel < 15)
        begin
            // buffer may end early
            repeat ($urandom_range(1, 2)) put_item(0);
            cut = $urandom_range(1, cbor_bytes.size());
            while (cbor_bytes.size() > cut)
                cbor_bytes.delete(cbor_bytes.size() - 1);
        end
        else if (sel < 17)
        begin
            if ($urandom_range(0, 1))
                put_item(0);
            put_bad();
            repeat ($urandom_range(0, 3)) cbor_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (sel < 18)
        begin
            // string of up to max_len bytes, usually cut short
            put_head($urandom_range(0, 1) ? MT_BYTES : MT_TEXT,
                     64'($urandom_range(0, sb.max_len)));
            repeat ($urandom_range(0, 4)) cbor_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
            repeat ($urandom_range(1, 8)) cbor_bytes.push_back(8'($urandom_range(0, 255)));
        send_buffer();
    endtask

    task automatic random_phase(int unsigned count);
        int unsigned goal;
        goal = sb.live_bytes + count;
        while (sb.live_bytes < goal)
        begin
            tx_mode = idle_mode_t'($urandom_range(0, 2));
            rx_mode = idle_mode_t'($urandom_range(0, 2));
            if ($urandom_range(0, 39) == 0)
                drain_results();
            random_buffer();
        end
    endtask

    initial
    begin : stimulus
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        tx_mode = IDLE_SOME;
        rx_mode = IDLE_SOME;
        for (int i = 0; i < 23; i++)
            send_byte(opening_bytes[i][7:0], opening_bytes[i][8]);

        // nested maximal maps until the owed count overflows
        cbor_bytes.delete();
        repeat (130)
        begin
            cbor_bytes.push_back({MT_MAP, AI_MAX_IMM + 5'd3});
            cbor_bytes.push_back(8'h00);
            repeat (3) cbor_bytes.push_back(8'hff);
        end
        cbor_bytes.push_back(8'h00);
        send_buffer();

        random_phase(PHASE_BYTES / 2);

        // receiver holds off while the sender keeps offering
        hold_cycles = LONG_HOLD;
        tx_mode = IDLE_NONE;
        repeat (4)
        begin
            cbor_bytes.delete();
            repeat (3) put_item(0);
            send_buffer();
        end
        random_phase(PHASE_BYTES / 2);

        drain_results();
        write_len_limit(24'd0);
        random_phase(PHASE_BYTES);

        drain_results();
        write_len_limit(24'd2);
        random_phase(PHASE_BYTES);

        drain_results();
        write_len_limit(24'($urandom_range(3, 24'hfffffe)));
        random_phase(PHASE_BYTES);

        drain_results();
        write_len_limit(LEN_LIMIT_RESET);
        random_phase(PHASE_BYTES);

        drain_results();
        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : result_sink
        result_t got;
        int stall_len;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            stall_len = draw_gap(rx_mode);
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(negedge clk);
            end
            out_stall <= 1'b0;
            // result transaction
            do @(posedge clk); while (out_valid !== 1'b1);
            got = {what, item_type, value, header_size, payload_byte,
                   item_done, top_done, error_code};
            sb.check_result(got);
            @(negedge clk);
        end
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== cbor_item_tokenizer.f =====
+incdir+hw/rtl
hw/rtl/cbortok_pkg.sv
hw/rtl/cbortok_step.sv
hw/rtl/cbor_item_tokenizer.sv
tb/sv/testbench.sv
